### rtl/lumi_pkg.sv
// package: shared constants, types and fixed-point helpers of the lu matrix inversion block
package lumi_pkg;
	localparam int MAX_ORDER = 8;
	localparam int FRAC_BITS = 16;
	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int AW = $clog2(DEPTH);
	localparam int IW = $clog2(MAX_ORDER);
	localparam int NW = $clog2(MAX_ORDER + 1);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = 32;
	localparam int QW = DW + FRAC_BITS + 1;

	localparam logic [1:0] REG_SIZE = 2'd0;
	localparam logic [1:0] REG_EPS  = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;

	localparam logic [0:0] MODE_INV = 1'b0;
	localparam logic [0:0] MODE_LU  = 1'b1;

	localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;
	localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

	typedef logic signed [DW-1:0] word_t;

	// divider request and reply between the sequencer and the divider
	typedef struct packed {
		logic  start;
		word_t num;
		word_t den;
	} div_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		word_t quo;
	} div_rsp_t;

	function automatic word_t sat64(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return SMAX;
		if (v < -64'sd2147483648) return SMIN;
		return v[DW-1:0];
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return AW'({r, c});
	endfunction
endpackage

### rtl/lumi_ram.sv
// generic dual-port ram with registered read
module lumi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/lumi_div.sv
// restoring fixed-point divider, one quotient bit per cycle, round half away from zero
module lumi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  lumi_pkg::div_req_t req,
	output lumi_pkg::div_rsp_t rsp
);
	import lumi_pkg::*;

	logic [QW-1:0] num_q;
	logic [QW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quo_q;
	logic [6:0]    cnt_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	word_t         res_q;
	logic [QW:0]   trial;
	logic [QW:0]   shifted;
	logic [QW:0]   qr;
	logic [QW:0]   q2;
	logic signed [QW+1:0] sq;
	logic [DW-1:0] mn;
	logic [DW-1:0] md;

	assign mn = req.num[DW-1] ? DW'(-req.num) : DW'(req.num);
	assign md = req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
	assign shifted = {rem_q[QW-1:0], num_q[QW-1]};
	assign trial = shifted - {1'b0, {(QW-DW){1'b0}}, den_q};
	// quotient bits carry one extra fractional bit for rounding
	assign qr = {1'b0, quo_q};
	assign q2 = (qr + (QW+1)'(1)) >> 1;
	assign sq = neg_q ? -$signed({1'b0, q2}) : $signed({1'b0, q2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {mn, {(FRAC_BITS+1){1'b0}}};
			den_q <= md;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= req.num[DW-1] ^ req.den[DW-1];
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!trial[QW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
		if (busy_q && cnt_q == 7'd1) res_q <= 32'sd0;
	end

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		if (den_q == '0) rsp.quo = '0;
		else if (sq > $signed((QW+2)'(SMAX))) rsp.quo = SMAX;
		else if (sq < -$signed((QW+2)'(64'sd2147483648))) rsp.quo = SMIN;
		else rsp.quo = sq[DW-1:0] | res_q;
	end
endmodule

### rtl/lumi_mac.sv
// shared multiply-subtract unit: acc minus rounded saturated product
module lumi_mac (
	input  logic                clk,
	input  logic                en,
	input  lumi_pkg::word_t     a,
	input  lumi_pkg::word_t     b,
	input  logic signed [63:0]  acc_in,
	output logic signed [63:0]  acc_out
);
	import lumi_pkg::*;

	logic signed [63:0] prod_s1;
	logic signed [63:0] acc_s1;
	logic signed [63:0] rnd;

	assign rnd = (prod_s1 + (64'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 64'(a) * 64'(b);
			acc_s1  <= acc_in;
		end
	end

	assign acc_out = acc_s1 - 64'(sat64(rnd));
endmodule

### rtl/lumi_seq.sv
// sequencer: load, factorisation, inverse-mode triangular solves, result output
module lumi_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  lumi_pkg::word_t        element,
	output logic                   out_valid,
	input  logic                   out_stall,
	output lumi_pkg::word_t        value,
	output logic [2:0]             row,
	output logic [2:0]             col,
	output logic                   last,
	output logic                   status,
	input  logic [3:0]             size_q,
	input  logic [15:0]            eps_q,
	input  logic                   mode_q
);
	import lumi_pkg::*;

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_INIT  = 4'd1;
	localparam logic [3:0] ST_RD_A  = 4'd2;
	localparam logic [3:0] ST_WT_A  = 4'd3;
	localparam logic [3:0] ST_RD_X  = 4'd4;
	localparam logic [3:0] ST_RD_Y  = 4'd5;
	localparam logic [3:0] ST_MUL   = 4'd6;
	localparam logic [3:0] ST_ACC   = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_DWT   = 4'd9;
	localparam logic [3:0] ST_WR    = 4'd10;
	localparam logic [3:0] ST_ORD   = 4'd11;
	localparam logic [3:0] ST_OWT   = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;
	localparam logic [3:0] ST_SING  = 4'd14;

	// phases of the inner loop nest
	localparam logic [1:0] PH_U   = 2'd0;
	localparam logic [1:0] PH_L   = 2'd1;
	localparam logic [1:0] PH_FWD = 2'd2;
	localparam logic [1:0] PH_BWD = 2'd3;

	logic [3:0]    st_q;
	logic [1:0]    ph_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] lr_q, lc_q;
	logic [IW-1:0] i_q, j_q, k_q, c_q;
	logic [NW-1:0] n;
	logic [IW-1:0] nm1;
	logic signed [63:0] acc_q;
	word_t         x_q, piv_q, res_q;
	logic          wk_q;

	logic          w_we;
	logic [AW-1:0] w_wa, w_ra, s_wa, s_ra;
	word_t         w_wd, w_rd, s_wd, s_rd;
	logic          s_we;
	logic          mac_en;
	logic signed [63:0] mac_out;
	word_t         y_op;
	div_req_t      dreq;
	div_rsp_t      drsp;
	logic          kdone;
	logic [IW-1:0] kend;

	always_comb begin
		if (size_q == 4'd0) n = NW'(1);
		else if (size_q > 4'(MAX_ORDER)) n = NW'(MAX_ORDER);
		else n = NW'(size_q);
	end
	assign nm1 = IW'(n - NW'(1));

	lumi_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_work (
		.clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd)
	);
	lumi_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_sol (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
	);
	// the solves take their second operand from the solution store
	assign y_op = (ph_q == PH_FWD || ph_q == PH_BWD) ? s_rd : w_rd;
	lumi_mac u_mac (
		.clk(clk), .en(mac_en), .a(x_q), .b(y_op), .acc_in(acc_q), .acc_out(mac_out)
	);
	lumi_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in_stall = (st_q != ST_LOAD);

	// inner k loop bound for each phase
	always_comb begin
		case (ph_q)
			PH_U:    kend = i_q;
			PH_L:    kend = j_q;
			PH_FWD:  kend = i_q;
			default: kend = nm1;
		endcase
	end
	// true when no more product terms remain
	always_comb begin
		case (ph_q)
			PH_BWD:  kdone = (k_q >= nm1) || (i_q == nm1);
			default: kdone = (k_q >= kend);
		endcase
	end

	// x operand address and the y operand address
	always_comb begin
		w_ra = addr_of(i_q, j_q);
		s_ra = addr_of(i_q, c_q);
		case (st_q)
			ST_RD_A: begin
				case (ph_q)
					PH_U, PH_L: w_ra = addr_of(i_q, j_q);
					PH_BWD:     s_ra = addr_of(i_q, c_q);
					default:    w_ra = addr_of(i_q, j_q);
				endcase
			end
			ST_RD_X: w_ra = addr_of(i_q, k_q);
			ST_RD_Y: begin
				if (ph_q == PH_U || ph_q == PH_L) w_ra = addr_of(k_q, j_q);
				else s_ra = addr_of(k_q, c_q);
			end
			ST_DIV:  w_ra = addr_of(i_q, i_q);
			ST_ORD:  begin
				w_ra = addr_of(lr_q, lc_q);
				s_ra = addr_of(lr_q, lc_q);
			end
			default: ;
		endcase
	end

	assign mac_en = (st_q == ST_MUL);

	always_comb begin
		w_we = 1'b0;
		w_wa = addr_of(i_q, j_q);
		w_wd = res_q;
		s_we = 1'b0;
		s_wa = addr_of(i_q, c_q);
		s_wd = res_q;
		if (st_q == ST_LOAD && in_valid) begin
			w_we = 1'b1;
			w_wa = (cnt_q >= CW'(n * n)) ? '0 : addr_of(lr_q, lc_q);
			w_wd = element;
		end else if (st_q == ST_WR) begin
			if (ph_q == PH_U || ph_q == PH_L) w_we = 1'b1;
			else s_we = 1'b1;
		end
	end

	// the diagonal for the backward solve is on the work read port in the start cycle
	always_comb begin
		dreq.start = (st_q == ST_DWT) && !drsp.busy && !drsp.done && !wk_q;
		dreq.num   = sat64(acc_q);
		dreq.den   = (ph_q == PH_BWD) ? w_rd : piv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_LOAD;
			ph_q  <= PH_U;
			cnt_q <= '0;
			lr_q  <= '0;
			lc_q  <= '0;
			i_q   <= '0;
			j_q   <= '0;
			k_q   <= '0;
			c_q   <= '0;
			wk_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			case (st_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (cnt_q >= CW'(n * n) - CW'(1) || cnt_q >= CW'(n * n)) begin
							cnt_q <= '0;
							lr_q  <= '0;
							lc_q  <= '0;
							if (cnt_q == CW'(n * n) - CW'(1)) st_q <= ST_INIT;
							else begin
								cnt_q <= CW'(1);
								lc_q  <= (nm1 == '0) ? '0 : IW'(1);
								if (nm1 == '0) st_q <= ST_INIT;
							end
						end else begin
							cnt_q <= cnt_q + CW'(1);
							if (lc_q == nm1) begin
								lc_q <= '0;
								lr_q <= lr_q + IW'(1);
							end else lc_q <= lc_q + IW'(1);
						end
					end
				end
				ST_INIT: begin
					ph_q <= PH_U;
					i_q  <= '0;
					j_q  <= '0;
					k_q  <= '0;
					c_q  <= '0;
					st_q <= ST_RD_A;
				end
				ST_RD_A: st_q <= ST_WT_A;
				ST_WT_A: begin
					case (ph_q)
						PH_FWD:  acc_q <= (i_q == c_q) ? 64'(ONE) : 64'sd0;
						PH_BWD:  acc_q <= 64'(s_rd);
						default: acc_q <= 64'(w_rd);
					endcase
					k_q  <= (ph_q == PH_BWD) ? i_q + IW'(1) : '0;
					st_q <= ST_RD_X;
					if (ph_q == PH_BWD ? (i_q == nm1) : (kend == '0)) st_q <= ST_DIV;
				end
				ST_RD_X: st_q <= ST_RD_Y;
				ST_RD_Y: begin
					x_q  <= w_rd;
					st_q <= ST_MUL;
				end
				ST_MUL: st_q <= ST_ACC;
				ST_ACC: begin
					acc_q <= 64'(sat64(mac_out)) == mac_out ? mac_out : mac_out;
					if (kdone || k_q + IW'(1) >= kend && ph_q != PH_BWD ||
					    ph_q == PH_BWD && k_q == nm1) begin
						st_q <= ST_DIV;
					end else begin
						k_q  <= k_q + IW'(1);
						st_q <= ST_RD_X;
					end
				end
				ST_DIV: begin
					wk_q <= 1'b0;
					st_q <= ST_DWT;
					if (ph_q == PH_U || ph_q == PH_FWD) begin
						res_q <= sat64(acc_q);
						wk_q  <= 1'b1;
					end
				end
				ST_DWT: begin
					if (wk_q) st_q <= ST_WR;
					else if (drsp.done) begin
						res_q <= drsp.quo;
						st_q  <= ST_WR;
					end
				end
				ST_WR: begin
					wk_q <= 1'b0;
					st_q <= ST_RD_A;
					case (ph_q)
						PH_U: begin
							if (i_q == j_q) begin
								piv_q <= res_q;
								if (res_q == '0 || (res_q[DW-1] ? DW'(-res_q) : DW'(res_q)) <
								    DW'(eps_q)) st_q <= ST_SING;
								else if (j_q == nm1) begin
									st_q <= (mode_q == MODE_LU) ? ST_ORD : ST_RD_A;
									ph_q <= PH_FWD;
									i_q  <= '0;
									c_q  <= '0;
									lr_q <= '0;
									lc_q <= '0;
								end else begin
									ph_q <= PH_L;
									i_q  <= j_q + IW'(1);
								end
							end else i_q <= i_q + IW'(1);
						end
						PH_L: begin
							if (i_q == nm1) begin
								ph_q <= PH_U;
								j_q  <= j_q + IW'(1);
								i_q  <= '0;
							end else i_q <= i_q + IW'(1);
						end
						PH_FWD: begin
							if (i_q == nm1) ph_q <= PH_BWD;
							else i_q <= i_q + IW'(1);
						end
						default: begin
							if (i_q == '0) begin
								if (c_q == nm1) begin
									st_q <= ST_ORD;
									lr_q <= '0;
									lc_q <= '0;
								end else begin
									c_q  <= c_q + IW'(1);
									ph_q <= PH_FWD;
								end
							end else i_q <= i_q - IW'(1);
						end
					endcase
				end
				ST_ORD: st_q <= ST_OWT;
				ST_OWT: begin
					value  <= (mode_q == MODE_LU) ? w_rd : s_rd;
					row    <= 3'(lr_q);
					col    <= 3'(lc_q);
					last   <= (lr_q == nm1) && (lc_q == nm1);
					status <= 1'b0;
					out_valid <= 1'b1;
					st_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (last) begin
							st_q  <= ST_LOAD;
							cnt_q <= '0;
							lr_q  <= '0;
							lc_q  <= '0;
						end else begin
							st_q <= ST_ORD;
							if (lc_q == nm1) begin
								lc_q <= '0;
								lr_q <= lr_q + IW'(1);
							end else lc_q <= lc_q + IW'(1);
						end
					end
				end
				ST_SING: begin
					if (!out_valid) begin
						value  <= '0;
						row    <= '0;
						col    <= '0;
						last   <= 1'b1;
						status <= 1'b1;
						out_valid <= 1'b1;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						st_q  <= ST_LOAD;
						cnt_q <= '0;
						lr_q  <= '0;
						lc_q  <= '0;
					end
				end
				default: st_q <= ST_LOAD;
			endcase
			if (st_q == ST_WR && ph_q == PH_BWD && i_q == '0 && c_q == nm1) begin
				lr_q <= '0;
				lc_q <= '0;
			end
		end
	end
endmodule

### rtl/lu_matrix_inversion.sv
// top level of the lu matrix inversion block
// usage:
//   configuration: write matrix_size (index 0), pivot_epsilon (1), output_mode (2)
//   through cfg_we / cfg_index / cfg_data while the block is idle
//   input channel: in_valid / in_stall carry one element per request in row-major
//   order; in_stall is low only while elements are being loaded
//   after the n*n-th element the block factors the matrix with one shared
//   multiply-subtract unit and one bit-serial divider; each product term steps
//   through the states rd_x, rd_y, mul and acc, and each division waits in dwt
//   until the divider is done before the quotient is written back
//   output channel: out_valid / out_stall carry n*n results (inverse or packed lu)
//   row-major, with out_valid low between results, last set on the final one;
//   a singular pivot gives one result with status set instead
//   a stalled result holds until taken; the block then returns to loading
//   reset clears the load count, the sequencer and the registers to their
//   defaults (order 8, epsilon 1, inverse mode); the matrix stores are not cleared
module lu_matrix_inversion (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  lumi_pkg::word_t    element,
	output logic               out_valid,
	input  logic               out_stall,
	output lumi_pkg::word_t    value,
	output logic [2:0]         row,
	output logic [2:0]         col,
	output logic               last,
	output logic               status
);
	import lumi_pkg::*;

	logic [3:0]  size_q;
	logic [15:0] eps_q;
	logic        mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 4'd8;
			eps_q  <= 16'd1;
			mode_q <= MODE_INV;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE: size_q <= cfg_data[3:0];
				REG_EPS:  eps_q  <= cfg_data;
				REG_MODE: mode_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	lumi_seq u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .element(element),
		.out_valid(out_valid), .out_stall(out_stall),
		.value(value), .row(row), .col(col), .last(last), .status(status),
		.size_q(size_q), .eps_q(eps_q), .mode_q(mode_q)
	);
endmodule

### rtl/lumi_checker.sv
// port-level checker for the lu matrix inversion block
module lumi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        last,
	input logic        status,
	input logic [2:0]  row,
	input logic [2:0]  col
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row) && $stable(col))
		else $error("stalled result changed");
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last && row == 3'd0 && col == 3'd0)
		else $error("singular result malformed");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("loading while emitting");
	a_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> !out_valid)
		else $error("results too close");
endmodule

bind lu_matrix_inversion lumi_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .last(last), .status(status),
	.row(row), .col(col)
);
